// ===== design/rlf_pkg.sv =====
`timescale 1ns / 1ps
// rlf_pkg: shared types and constants for the rgb led fader
// no dependencies; used by every module of the block
package rlf_pkg;

   localparam int unsigned NUM_OUT_CH     = 3;
   localparam int unsigned CSR_INDEX_W    = 3;
   localparam int unsigned CSR_DATA_W     = 10;
   localparam int unsigned PERIOD_W       = 10;
   localparam int unsigned SCALED_W       = 9;
   localparam int unsigned GAIN_SHIFT     = 7 + 8;
   localparam logic [7:0]  MIN_ANIMATE_LEN = 8'd4;
   localparam logic [7:0]  GAIN_RESET      = 8'd255;
   localparam logic [9:0]  PERIOD_RESET    = 10'd600;

   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_ANIMATE  = 2'd1;
   localparam logic [1:0] REQ_READ     = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [2:0] CSR_GAIN_RED       = 3'd0;
   localparam logic [2:0] CSR_GAIN_GREEN     = 3'd1;
   localparam logic [2:0] CSR_GAIN_BLUE      = 3'd2;
   localparam logic [2:0] CSR_COMMON_CATHODE = 3'd3;
   localparam logic [2:0] CSR_PWM_PERIOD     = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] target_red;
      logic [7:0] target_green;
      logic [7:0] target_blue;
      logic [7:0] fade_speed;
      logic [7:0] payload_len;
   } req_item_type;

   typedef struct packed {
      logic [9:0] duty_red;
      logic [9:0] duty_green;
      logic [9:0] duty_blue;
      logic [2:0] pwm_on;
      logic       timer_power_on;
      logic [7:0] level_red;
      logic [7:0] level_green;
      logic [7:0] level_blue;
   } rsp_item_type;

   typedef struct packed {
      logic tick;
      logic animate;
   } lane_ctrl_type;

   typedef struct packed {
      logic                common_cathode;
      logic [PERIOD_W-1:0] pwm_period;
   } pwm_cfg_type;

endpackage

// ===== design/rgb_led_fader_pwm.sv =====
`timescale 1ns / 1ps
// rgb_led_fader_pwm: three-channel led fader with pwm duty results
// depends on rlf_pkg, rlf_lane, rlf_merge
//
//   port group   dir   handshake          payload
//   req_         in    req_valid/ready    rlf_pkg::req_item_type
//   rsp_         out   rsp_valid/ready    rlf_pkg::rsp_item_type
//   csr_         in    csr_we             csr_index, csr_wdata
//
// one item per cycle unless the result side stalls; each result passes the lane state, then the result register
// channel state updates at the accepting edge, duties are formed from it when the pending item moves on
// one pending item plus the result register decouple the two sides
// synchronous reset clears fade state and restores register defaults
module rgb_led_fader_pwm #(
   parameter int unsigned CHANNELS = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rlf_pkg::req_item_type               req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rlf_pkg::rsp_item_type               rsp_item,
   input  logic                                csr_we,
   input  logic [rlf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rlf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [7:0]           gain_ff [rlf_pkg::NUM_OUT_CH];
   logic                 cc_ff;
   logic [9:0]           period_ff;

   logic                 accept;
   logic                 can_accept;
   rlf_pkg::lane_ctrl_type lane_ctrl;
   rlf_pkg::pwm_cfg_type pwm_cfg;
   logic [7:0]           targets [rlf_pkg::NUM_OUT_CH];
   logic [rlf_pkg::SCALED_W-1:0] lane_scaled [CHANNELS];
   logic [7:0]           lane_level [CHANNELS];
   logic [rlf_pkg::SCALED_W-1:0] out_scaled [rlf_pkg::NUM_OUT_CH];
   logic [7:0]           out_level [rlf_pkg::NUM_OUT_CH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rlf_pkg::NUM_OUT_CH; i++) begin
            gain_ff[i] <= rlf_pkg::GAIN_RESET;
         end
         cc_ff     <= 1'b0;
         period_ff <= rlf_pkg::PERIOD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rlf_pkg::CSR_GAIN_RED:       gain_ff[0] <= csr_wdata[7:0];
            rlf_pkg::CSR_GAIN_GREEN:     gain_ff[1] <= csr_wdata[7:0];
            rlf_pkg::CSR_GAIN_BLUE:      gain_ff[2] <= csr_wdata[7:0];
            rlf_pkg::CSR_COMMON_CATHODE: cc_ff      <= csr_wdata[0];
            rlf_pkg::CSR_PWM_PERIOD:     period_ff  <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign req_ready = can_accept;
   assign accept    = req_valid && can_accept;

   assign lane_ctrl.tick    = accept && (req_item.req_type == rlf_pkg::REQ_TICK);
   assign lane_ctrl.animate = accept && (req_item.req_type == rlf_pkg::REQ_ANIMATE)
                              && (req_item.payload_len >= rlf_pkg::MIN_ANIMATE_LEN);

   assign pwm_cfg.common_cathode = cc_ff;
   assign pwm_cfg.pwm_period     = period_ff;

   assign targets[0] = req_item.target_red;
   assign targets[1] = req_item.target_green;
   assign targets[2] = req_item.target_blue;

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      if (i < rlf_pkg::NUM_OUT_CH) begin : g_colour
         rlf_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (lane_ctrl),
            .target (targets[i]),
            .speed  (req_item.fade_speed),
            .gain   (gain_ff[i]),
            .level  (lane_level[i]),
            .scaled (lane_scaled[i])
         );
      end else begin : g_spare
         rlf_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (lane_ctrl),
            .target (8'd0),
            .speed  (req_item.fade_speed),
            .gain   (8'd0),
            .level  (lane_level[i]),
            .scaled (lane_scaled[i])
         );
      end
   end

   for (genvar i = 0; i < rlf_pkg::NUM_OUT_CH; i++) begin : g_out
      if (i < CHANNELS) begin : g_used
         assign out_scaled[i] = lane_scaled[i];
         assign out_level[i]  = lane_level[i];
      end else begin : g_absent
         assign out_scaled[i] = '0;
         assign out_level[i]  = '0;
      end
   end

   rlf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .can_accept (can_accept),
      .cfg        (pwm_cfg),
      .scaled     (out_scaled),
      .level      (out_level),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_item   (rsp_item)
   );

endmodule

// ===== design/rlf_lane.sv =====
`timescale 1ns / 1ps
// rlf_lane: one colour channel - brightness, fade step and target, plus gain scaling
// depends on rlf_pkg
module rlf_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  rlf_pkg::lane_ctrl_type ctrl,
   input  logic [7:0]            target,
   input  logic [7:0]            speed,
   input  logic [7:0]            gain,
   output logic [7:0]            level,
   output logic [rlf_pkg::SCALED_W-1:0] scaled
);

   logic [15:0]        bright_ff, bright_in;
   logic signed [15:0] step_ff, step_in;
   logic [7:0]         target_ff, target_in;

   logic signed [17:0] sum_v;
   logic signed [9:0]  sum_hi;
   logic signed [9:0]  tgt_s;
   logic               snap;
   logic signed [16:0] diff;
   logic signed [25:0] prod;
   logic signed [25:0] half;
   logic signed [15:0] step_sat;
   logic [23:0]        scaled_prod;

   always_comb begin
      sum_v  = $signed({2'b00, bright_ff}) + $signed({{2{step_ff[15]}}, step_ff});
      sum_hi = sum_v[17:8];
      tgt_s  = $signed({2'b00, target_ff});
      snap   = (step_ff == 16'sd0)
             || (step_ff < 16'sd0 && (sum_v < 18'sd0 || sum_hi < tgt_s))
             || (step_ff > 16'sd0 && sum_v >= 18'sd0 && sum_hi > tgt_s);

      diff = $signed({1'b0, target, 8'h00}) - $signed({1'b0, bright_ff});
      prod = diff * $signed({1'b0, speed});
      half = prod >>> 1;
      if (half > 26'sd32767) begin
         step_sat = 16'sh7fff;
      end else if (half < -26'sd32768) begin
         step_sat = 16'sh8000;
      end else begin
         step_sat = half[15:0];
      end

      bright_in = bright_ff;
      step_in   = step_ff;
      target_in = target_ff;
      if (ctrl.tick) begin
         if (snap) begin
            step_in   = 16'sd0;
            bright_in = {target_ff, 8'h00};
         end else begin
            bright_in = sum_v[15:0];
         end
      end else if (ctrl.animate) begin
         target_in = target;
         step_in   = step_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= '0;
         step_ff   <= '0;
         target_ff <= '0;
      end else begin
         bright_ff <= bright_in;
         step_ff   <= step_in;
         target_ff <= target_in;
      end
   end

   assign scaled_prod = bright_ff * gain;
   assign scaled      = scaled_prod[rlf_pkg::GAIN_SHIFT +: rlf_pkg::SCALED_W];
   assign level       = bright_ff[15:8];

endmodule

// ===== design/rlf_merge.sv =====
`timescale 1ns / 1ps
// rlf_merge: makes pwm duties and flags from scaled lanes, holds the result register
// depends on rlf_pkg
module rlf_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   output logic                        can_accept,
   input  rlf_pkg::pwm_cfg_type        cfg,
   input  logic [rlf_pkg::SCALED_W-1:0] scaled [rlf_pkg::NUM_OUT_CH],
   input  logic [7:0]                  level  [rlf_pkg::NUM_OUT_CH],
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rlf_pkg::rsp_item_type       rsp_item
);

   logic                  pend_valid_ff, pend_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rlf_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                  pend_move;
   logic [9:0]            duty [rlf_pkg::NUM_OUT_CH];
   logic [2:0]            on_bits;
   logic [9:0]            c10;

   assign pend_move  = pend_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign can_accept = !pend_valid_ff || pend_move;

   always_comb begin
      on_bits = '0;
      c10     = '0;
      for (int i = 0; i < rlf_pkg::NUM_OUT_CH; i++) begin
         c10     = {1'b0, scaled[i]};
         duty[i] = '0;
         if (c10 != 10'd0) begin
            on_bits[i] = 1'b1;
            if (cfg.common_cathode) begin
               if (cfg.pwm_period == 10'd0) begin
                  duty[i] = '0;
               end else if (c10 >= cfg.pwm_period) begin
                  duty[i] = cfg.pwm_period - 10'd1;
               end else begin
                  duty[i] = c10;
               end
            end else begin
               duty[i] = (c10 >= cfg.pwm_period) ? 10'd0 : cfg.pwm_period - c10;
            end
         end
      end

      rsp_item_in                = rsp_item_ff;
      if (pend_move) begin
         rsp_item_in.duty_red       = duty[0];
         rsp_item_in.duty_green     = duty[1];
         rsp_item_in.duty_blue      = duty[2];
         rsp_item_in.pwm_on         = on_bits;
         rsp_item_in.timer_power_on = |on_bits;
         rsp_item_in.level_red      = level[0];
         rsp_item_in.level_green    = level[1];
         rsp_item_in.level_blue     = level[2];
      end

      pend_valid_in = accept ? 1'b1 : (pend_move ? 1'b0 : pend_valid_ff);
      rsp_valid_in  = pend_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
